@@ rtl/macd_pkg.sv @@
// ----------------------------------------------------------------------------
// macd_pkg
// Shared constants, codes and controller/datapath interface types for the
// MACD crossover detector.
// ----------------------------------------------------------------------------
package macd_pkg;

    localparam int PRICE_BITS        = 32;
    localparam int MAX_SIGNAL_PERIOD = 64;
    localparam int HIST_AW           = $clog2(MAX_SIGNAL_PERIOD);
    localparam int ACC_W             = 64;
    localparam int FRAC_SHIFT        = 16;
    localparam int DIV_W             = ACC_W + FRAC_SHIFT;
    localparam int DVS_W             = 9;
    localparam int DCNT_W            = $clog2(DIV_W);
    localparam int CNT_W             = 9;
    localparam int CMP_W             = 10;
    localparam int OUT_W             = 33;
    localparam int WSUM_W            = 40;
    localparam int PER_W             = 8;
    localparam int SIGP_W            = 7;
    localparam int XO_W              = 2;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 8;
    localparam int OUT_DATA_W        = ((2 * OUT_W + XO_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FAST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL = 2'd2;

    localparam logic [PER_W-1:0]  FAST_RESET   = 8'd12;
    localparam logic [PER_W-1:0]  SLOW_RESET   = 8'd26;
    localparam logic [SIGP_W-1:0] SIGNAL_RESET = 7'd9;

    localparam logic [XO_W-1:0] XO_NONE = 2'd0;
    localparam logic [XO_W-1:0] XO_BUY  = 2'd1;
    localparam logic [XO_W-1:0] XO_SELL = 2'd2;

    localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [OUT_W-1:0]  OUT_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0]  OUT_MIN   = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [WSUM_W-1:0] WSUM_MAX  = {1'b0, {(WSUM_W-1){1'b1}}};
    localparam logic [WSUM_W-1:0] WSUM_MIN  = {1'b1, {(WSUM_W-1){1'b0}}};

    typedef enum logic [1:0] {
        DIV_FAST = 2'd0,
        DIV_SLOW = 2'd1,
        DIV_MACD = 2'd2,
        DIV_SIG  = 2'd3
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        logic     fast_wr;
        logic     slow_wr;
        logic     macd_wr;
        logic     rd_old;
        logic     ring_sub;
        logic     ring_add;
        logic     sig_wr;
        logic     out_wr;
    } cmd_t;

    typedef struct packed {
        logic fast_div;
        logic slow_div;
        logic macd_div;
        logic sig_div;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

@@ rtl/macd_crossover_detector.sv @@
// ----------------------------------------------------------------------------
// macd_crossover_detector
// MACD and signal line over a price stream, with buy/sell crossover codes.
// ----------------------------------------------------------------------------
// sequence: load, fast, slow, macd, ring read, ring subtract, ring add, signal, output;
//   each step that runs the shared divider (80-bit dividend) waits for its done, and at
//   most three of the fast, slow, macd and signal steps divide (fast and macd never both)
// throughput: one sample at a time; next sample taken the cycle after the result
//   is queued, and queuing waits while a held result is not yet taken
// reset: rst_n clears the series and loads periods 12/26/9; history ring not cleared
module macd_crossover_detector (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [macd_pkg::PRICE_BITS-1:0]   s_tdata,   // price
    input  logic [0:0]                        s_tuser,   // restart
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [macd_pkg::OUT_DATA_W-1:0]   m_tdata,   // macd_value, signal_value, crossover
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [macd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [macd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import macd_pkg::*;

    cmd_t    cmd;
    status_t st;
    logic    cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    macd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    macd_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_wr),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_price   (s_tdata),
        .in_restart (s_tuser[0]),
        .cmd        (cmd),
        .st         (st),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

@@ rtl/macd_div.sv @@
// ----------------------------------------------------------------------------
// macd_div
// Shared restoring divider, one quotient bit per cycle, narrow divisor.
// ----------------------------------------------------------------------------
module macd_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [macd_pkg::DIV_W-1:0]   dividend,
    input  logic [macd_pkg::DVS_W-1:0]   divisor,
    output logic [macd_pkg::ACC_W-1:0]   quotient,
    output logic                         done
);
    import macd_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DIV_W-1:0]  q_reg, q_next;
    logic [DVS_W:0]    trial;
    logic              ge;

    assign trial = {rem_reg, q_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            q_next    = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            q_next   = {q_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign quotient = q_reg[ACC_W-1:0];
    assign done     = done_reg;

endmodule

@@ rtl/macd_ctrl.sv @@
// ----------------------------------------------------------------------------
// macd_ctrl
// Sequencer that walks one sample through the averaging, ring and signal steps.
// ----------------------------------------------------------------------------
module macd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  macd_pkg::status_t st,
    output macd_pkg::cmd_t    cmd
);
    import macd_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'h0001,
        ST_FAST   = 13'h0002,
        ST_FAST_W = 13'h0004,
        ST_SLOW   = 13'h0008,
        ST_SLOW_W = 13'h0010,
        ST_MACD   = 13'h0020,
        ST_MACD_W = 13'h0040,
        ST_RD     = 13'h0080,
        ST_SUB    = 13'h0100,
        ST_ADD    = 13'h0200,
        ST_SIG    = 13'h0400,
        ST_SIG_W  = 13'h0800,
        ST_OUT    = 13'h1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_FAST;
                end
            end
            ST_FAST:
            begin
                cmd.div_sel = DIV_FAST;
                if (st.fast_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_FAST_W;
                end
                else
                begin
                    cmd.fast_wr = 1'b1;
                    state_next  = ST_SLOW;
                end
            end
            ST_FAST_W:
            begin
                if (st.div_done)
                begin
                    cmd.fast_wr = 1'b1;
                    state_next  = ST_SLOW;
                end
            end
            ST_SLOW:
            begin
                cmd.div_sel = DIV_SLOW;
                if (st.slow_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_SLOW_W;
                end
                else
                begin
                    cmd.slow_wr = 1'b1;
                    state_next  = ST_MACD;
                end
            end
            ST_SLOW_W:
            begin
                if (st.div_done)
                begin
                    cmd.slow_wr = 1'b1;
                    state_next  = ST_MACD;
                end
            end
            ST_MACD:
            begin
                cmd.div_sel = DIV_MACD;
                if (st.macd_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_MACD_W;
                end
                else
                begin
                    cmd.macd_wr = 1'b1;
                    state_next  = ST_RD;
                end
            end
            ST_MACD_W:
            begin
                if (st.div_done)
                begin
                    cmd.macd_wr = 1'b1;
                    state_next  = ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.rd_old = 1'b1;
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                cmd.ring_sub = 1'b1;
                state_next   = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.ring_add = 1'b1;
                state_next   = ST_SIG;
            end
            ST_SIG:
            begin
                cmd.div_sel = DIV_SIG;
                if (st.sig_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_SIG_W;
                end
                else
                begin
                    cmd.sig_wr = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_SIG_W:
            begin
                if (st.div_done)
                begin
                    cmd.sig_wr = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_wr = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/macd_dp.sv @@
// ----------------------------------------------------------------------------
// macd_dp
// Datapath: settings, averages, MACD ring, window sum, divider and output.
// ----------------------------------------------------------------------------
module macd_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [macd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [macd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [macd_pkg::PRICE_BITS-1:0]   in_price,
    input  logic                              in_restart,
    input  macd_pkg::cmd_t                    cmd,
    output macd_pkg::status_t                 st,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [macd_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import macd_pkg::*;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    endfunction

    // settings
    logic [PER_W-1:0]  fast_per_reg;
    logic [PER_W-1:0]  slow_per_reg;
    logic [SIGP_W-1:0] sig_per_reg;

    // series state
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ACC_W-1:0]   fast_reg, fast_next;
    logic [ACC_W-1:0]   slow_reg, slow_next;
    logic [WSUM_W-1:0]  ws_reg, ws_next;
    logic [HIST_AW-1:0] head_reg, head_next;
    logic [OUT_W-1:0]   pmacd_reg, pmacd_next;
    logic [OUT_W-1:0]   psig_reg, psig_next;
    logic               ovalid_reg, ovalid_next;

    // per-sample working registers
    logic [PRICE_BITS-1:0] price_reg;
    logic [OUT_W-1:0]      macd_reg;
    logic [OUT_W-1:0]      sig_reg;
    logic [OUT_W-1:0]      rd_reg;
    logic [OUT_DATA_W-1:0] odata_reg;

    logic [OUT_W-1:0] hist_mem [MAX_SIGNAL_PERIOD];

    logic [PER_W-1:0]  fp, sp;
    logic [SIGP_W-1:0] gp;
    logic [CMP_W-1:0]  cnt_x, sp_gp;
    logic              lt_fp, lt_sp, fast_seed, slow_seed;
    logic              ring_on, sub_on, sig_on, cross_on;
    logic [ACC_W-1:0]  p64, fsum, ssum, fdiff, sdiff;
    logic              f_up, s_up;
    logic [DIV_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
    logic [ACC_W-1:0]  quot;
    logic              div_done;
    logic [ACC_W-1:0]  fval, mdiff;
    logic              m_ge;
    logic [ACC_W-FRAC_SHIFT-1:0] mmag;
    logic [OUT_W-1:0]  macd_calc, sig_calc;
    logic [WSUM_W-1:0] ws_mag;
    logic [WSUM_W-1:0] sq;
    logic [WSUM_W:0]   ws_sub, ws_add;
    logic [HIST_AW-1:0] old_addr;
    logic [XO_W-1:0]   xo;

    assign fp = (fast_per_reg == '0) ? PER_W'(1) : fast_per_reg;
    assign sp = (slow_per_reg == '0) ? PER_W'(1) : slow_per_reg;
    assign gp = (sig_per_reg == '0) ? SIGP_W'(1) :
                (sig_per_reg > SIGP_W'(MAX_SIGNAL_PERIOD)) ? SIGP_W'(MAX_SIGNAL_PERIOD) :
                sig_per_reg;

    assign cnt_x     = CMP_W'(count_reg);
    assign sp_gp     = CMP_W'(sp) + CMP_W'(gp);
    assign lt_fp     = count_reg < CNT_W'(fp);
    assign lt_sp     = count_reg < CNT_W'(sp);
    assign fast_seed = count_reg == CNT_W'(fp);
    assign slow_seed = count_reg == CNT_W'(sp);
    assign ring_on   = cnt_x >= CMP_W'(sp) + CMP_W'(1);
    assign sub_on    = cnt_x > sp_gp;
    assign sig_on    = cnt_x >= sp_gp;
    assign cross_on  = cnt_x > sp_gp;

    assign p64   = {{(ACC_W-PRICE_BITS-FRAC_SHIFT){1'b0}}, price_reg, {FRAC_SHIFT{1'b0}}};
    assign fsum  = sat_add(fast_reg, ACC_W'(price_reg));
    assign ssum  = sat_add(slow_reg, ACC_W'(price_reg));
    assign f_up  = p64 >= fast_reg;
    assign s_up  = p64 >= slow_reg;
    assign fdiff = f_up ? p64 - fast_reg : fast_reg - p64;
    assign sdiff = s_up ? p64 - slow_reg : slow_reg - p64;
    assign ws_mag = ws_reg[WSUM_W-1] ? WSUM_W'(-ws_reg) : ws_reg;

    // operand select for the shared divider
    always_comb
    begin
        case (cmd.div_sel)
            DIV_FAST:
            begin
                dividend = fast_seed ? {fsum, {FRAC_SHIFT{1'b0}}}
                                     : {{(FRAC_SHIFT-1){1'b0}}, fdiff, 1'b0};
                divisor  = fast_seed ? DVS_W'(fp) : DVS_W'(fp) + DVS_W'(1);
            end
            DIV_SLOW:
            begin
                dividend = slow_seed ? {ssum, {FRAC_SHIFT{1'b0}}}
                                     : {{(FRAC_SHIFT-1){1'b0}}, sdiff, 1'b0};
                divisor  = slow_seed ? DVS_W'(sp) : DVS_W'(sp) + DVS_W'(1);
            end
            DIV_MACD:
            begin
                dividend = {fast_reg, {FRAC_SHIFT{1'b0}}};
                divisor  = DVS_W'(fp);
            end
            DIV_SIG:
            begin
                dividend = DIV_W'(ws_mag);
                divisor  = DVS_W'(gp);
            end
            default:
            begin
                dividend = '0;
                divisor  = DVS_W'(1);
            end
        endcase
    end

    macd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quot),
        .done     (div_done)
    );

    // macd from the two averages
    assign fval  = lt_fp ? quot : fast_reg;
    assign m_ge  = fval >= slow_reg;
    assign mdiff = m_ge ? fval - slow_reg : slow_reg - fval;
    assign mmag  = mdiff[ACC_W-1:FRAC_SHIFT];

    always_comb
    begin
        if (lt_sp)
        begin
            macd_calc = '0;
        end
        else if (m_ge)
        begin
            macd_calc = (mmag > (ACC_W-FRAC_SHIFT)'(OUT_MAX)) ? OUT_MAX
                                                               : OUT_W'(mmag);
        end
        else
        begin
            macd_calc = (mmag >= (ACC_W-FRAC_SHIFT)'(OUT_MIN)) ? OUT_MIN
                                                                : OUT_W'(-OUT_W'(mmag));
        end
    end

    // signal mean, truncated toward zero
    assign sq = quot[WSUM_W-1:0];

    always_comb
    begin
        if (!sig_on)
        begin
            sig_calc = '0;
        end
        else if (!ws_reg[WSUM_W-1])
        begin
            sig_calc = (sq > WSUM_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(sq);
        end
        else
        begin
            sig_calc = (sq >= WSUM_W'(OUT_MIN)) ? OUT_MIN : OUT_W'(-OUT_W'(sq));
        end
    end

    assign old_addr = head_reg - HIST_AW'(gp);
    assign ws_sub   = {ws_reg[WSUM_W-1], ws_reg} - {{(WSUM_W+1-OUT_W){rd_reg[OUT_W-1]}}, rd_reg};
    assign ws_add   = {ws_reg[WSUM_W-1], ws_reg}
                      + {{(WSUM_W+1-OUT_W){macd_reg[OUT_W-1]}}, macd_reg};

    always_comb
    begin
        xo = XO_NONE;
        if (cross_on)
        begin
            if ($signed(macd_reg) > $signed(sig_reg) && $signed(pmacd_reg) <= $signed(psig_reg))
            begin
                xo = XO_BUY;
            end
            else if ($signed(macd_reg) < $signed(sig_reg)
                     && $signed(pmacd_reg) >= $signed(psig_reg))
            begin
                xo = XO_SELL;
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        fast_next   = fast_reg;
        slow_next   = slow_reg;
        ws_next     = ws_reg;
        head_next   = head_reg;
        pmacd_next  = pmacd_reg;
        psig_next   = psig_reg;
        ovalid_next = ovalid_reg && !m_tready;
        if (cmd.load)
        begin
            if (in_restart)
            begin
                count_next = CNT_W'(1);
                fast_next  = '0;
                slow_next  = '0;
                ws_next    = '0;
                head_next  = '0;
                pmacd_next = '0;
                psig_next  = '0;
            end
            else if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (cmd.fast_wr)
        begin
            if (lt_fp)
                fast_next = fsum;
            else if (fast_seed)
                fast_next = quot;
            else
                fast_next = f_up ? fast_reg + quot : fast_reg - quot;
        end
        if (cmd.slow_wr)
        begin
            if (lt_sp)
                slow_next = ssum;
            else if (slow_seed)
                slow_next = quot;
            else
                slow_next = s_up ? slow_reg + quot : slow_reg - quot;
        end
        if (cmd.ring_sub && sub_on)
        begin
            if (ws_sub[WSUM_W] != ws_sub[WSUM_W-1])
                ws_next = ws_sub[WSUM_W] ? WSUM_MIN : WSUM_MAX;
            else
                ws_next = ws_sub[WSUM_W-1:0];
        end
        if (cmd.ring_add && ring_on)
        begin
            if (ws_add[WSUM_W] != ws_add[WSUM_W-1])
                ws_next = ws_add[WSUM_W] ? WSUM_MIN : WSUM_MAX;
            else
                ws_next = ws_add[WSUM_W-1:0];
            head_next = head_reg + HIST_AW'(1);
        end
        if (cmd.out_wr)
        begin
            pmacd_next  = macd_reg;
            psig_next   = sig_reg;
            ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_per_reg <= FAST_RESET;
            slow_per_reg <= SLOW_RESET;
            sig_per_reg  <= SIGNAL_RESET;
            count_reg    <= '0;
            fast_reg     <= '0;
            slow_reg     <= '0;
            ws_reg       <= '0;
            head_reg     <= '0;
            pmacd_reg    <= '0;
            psig_reg     <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_FAST:   fast_per_reg <= cfg_data;
                    CFG_SLOW:   slow_per_reg <= cfg_data;
                    CFG_SIGNAL: sig_per_reg  <= cfg_data[SIGP_W-1:0];
                    default:    ;
                endcase
            end
            count_reg  <= count_next;
            fast_reg   <= fast_next;
            slow_reg   <= slow_next;
            ws_reg     <= ws_next;
            head_reg   <= head_next;
            pmacd_reg  <= pmacd_next;
            psig_reg   <= psig_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            price_reg <= in_price;
        if (cmd.macd_wr)
            macd_reg <= macd_calc;
        if (cmd.sig_wr)
            sig_reg <= sig_calc;
        if (cmd.rd_old)
            rd_reg <= hist_mem[old_addr];
        if (cmd.ring_add && ring_on)
            hist_mem[head_reg] <= macd_reg;
        if (cmd.out_wr)
            odata_reg <= OUT_DATA_W'({xo, sig_reg, macd_reg});
    end

    assign st.fast_div = !lt_fp;
    assign st.slow_div = !lt_sp;
    assign st.macd_div = !lt_sp && lt_fp;
    assign st.sig_div  = sig_on;
    assign st.div_done = div_done;
    assign st.out_free = !ovalid_reg || m_tready;

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

endmodule

@@ rtl/macd_checker.sv @@
// ----------------------------------------------------------------------------
// macd_checker
// Port-level checks on the MACD crossover detector.
// ----------------------------------------------------------------------------
module macd_port_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [macd_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import macd_pkg::*;

    // one sample in flight: no transfer right after a transfer
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a sample is in flight");

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // crossover code is never the unused value
    a_xo_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2*OUT_W+XO_W-1:2*OUT_W] <= XO_SELL))
        else $error("bad crossover code");

    // equal zero lines cannot cross
    a_xo_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[OUT_W-1:0] == '0 && m_tdata[2*OUT_W-1:OUT_W] == '0)
        |-> (m_tdata[2*OUT_W+XO_W-1:2*OUT_W] == XO_NONE))
        else $error("crossover flagged with both lines at zero");

    // result appears only after a sample transfer
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(m_tvalid)) |-> !s_tready || $past(!s_tready))
        else $error("result without sample");

endmodule

bind macd_crossover_detector macd_port_checker u_macd_checker (.*);
